FILE: rtl/core/lsct_pkg.sv
// Shared types and constants of the line sensor centroid tracker.
`timescale 1ns / 1ps

package lsct_pkg;

   localparam int PIN_W       = 8;
   localparam int COUNT_W     = 4;
   localparam int COEF_W      = 6;
   localparam int ODD_W       = 4;
   localparam int POS_W       = 16;
   localparam int LOST_W      = 16;
   localparam int SEQ_W       = 16;
   localparam int SIDE_W      = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_LOW    = 1'b0,
      CSR_CHANNEL_COUNT = 1'b1
   } csr_index_type;

   localparam logic [SIDE_W-1:0] SIDE_UNKNOWN = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_LEFT    = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT   = 2'd2;

   // One classified snapshot on its way from the front to the back.
   typedef struct packed {
      logic [PIN_W-1:0]         raw_bits;
      logic [PIN_W-1:0]         hit_bits;
      logic [COUNT_W-1:0]       hit_count;
      logic [PIN_W-1:0]         toggled_bits;
      logic [SEQ_W-1:0]         sequence_no;
      logic signed [COEF_W-1:0] coef_sum;
      logic signed [ODD_W-1:0]  odd_sum;
   } lsct_item_type;

endpackage

FILE: rtl/core/line_sensor_centroid_tracker_core.sv
// Top level of the line sensor centroid tracker: front end, queue and back end.
`timescale 1ns / 1ps

// Each request is one snapshot of up to eight line-sensor pins. The front end
// applies the polarity and channel count, forms the masks, the active count,
// the change against the previous snapshot and the sequence number, and takes
// one request per cycle into a two-entry queue while the queue is not full.
// The back end works on one snapshot at a time: with the line seen it runs the
// one-bit-per-cycle divider by the active count; with the line lost it skips
// the division. Results leave through an output register, so the back end
// carries on with the next snapshot while a result waits to be popped.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module line_sensor_centroid_tracker_core #(
   parameter int MAX_CHANNELS = 8,
   parameter int PITCH_SCALE  = 1000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lsct_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lsct_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [lsct_pkg::PIN_W-1:0]          req_pin_levels,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [lsct_pkg::PIN_W-1:0]          rsp_raw_mask,
   output logic [lsct_pkg::PIN_W-1:0]          rsp_active_mask,
   output logic [lsct_pkg::COUNT_W-1:0]        rsp_active_count,
   output logic                                rsp_line_detected,
   output logic signed [lsct_pkg::POS_W-1:0]   rsp_position,
   output logic signed [lsct_pkg::POS_W-1:0]   rsp_weighted_position,
   output logic signed [lsct_pkg::POS_W-1:0]   rsp_remembered_position,
   output logic [lsct_pkg::SIDE_W-1:0]         rsp_lost_side,
   output logic [lsct_pkg::LOST_W-1:0]         rsp_lost_count,
   output logic [lsct_pkg::PIN_W-1:0]          rsp_changed_mask,
   output logic [lsct_pkg::SEQ_W-1:0]          rsp_sequence_res
);
   import lsct_pkg::*;

   lsct_item_type front_item;
   lsct_item_type queue_item;
   logic          front_push;
   logic          queue_full;
   logic          queue_empty;
   logic          back_pop;

   lsct_front #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_pin_levels (req_pin_levels),
      .req_full       (req_full),
      .fifo_full      (queue_full),
      .item_push      (front_push),
      .item           (front_item)
   );

   lsct_fifo u_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_item),
      .full  (queue_full),
      .pop   (back_pop),
      .rdata (queue_item),
      .empty (queue_empty)
   );

   lsct_back #(
      .PITCH_SCALE (PITCH_SCALE)
   ) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .item_valid              (!queue_empty),
      .item                    (queue_item),
      .item_pop                (back_pop),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_raw_mask            (rsp_raw_mask),
      .rsp_active_mask         (rsp_active_mask),
      .rsp_active_count        (rsp_active_count),
      .rsp_line_detected       (rsp_line_detected),
      .rsp_position            (rsp_position),
      .rsp_weighted_position   (rsp_weighted_position),
      .rsp_remembered_position (rsp_remembered_position),
      .rsp_lost_side           (rsp_lost_side),
      .rsp_lost_count          (rsp_lost_count),
      .rsp_changed_mask        (rsp_changed_mask),
      .rsp_sequence_res        (rsp_sequence_res)
   );

endmodule

FILE: rtl/core/lsct_front.sv
// Front end: configuration registers, snapshot classification and per-snapshot history.
`timescale 1ns / 1ps

module lsct_front #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lsct_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lsct_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_push,
   input  logic [lsct_pkg::PIN_W-1:0]          req_pin_levels,
   output logic                                req_full,
   input  logic                                fifo_full,
   output logic                                item_push,
   output lsct_pkg::lsct_item_type             item
);
   import lsct_pkg::*;

   logic                     active_low_ff;
   logic [COUNT_W-1:0]       channel_count_ff;
   logic [PIN_W-1:0]         prev_mask_ff;
   logic                     sampled_once_ff;
   logic [SEQ_W-1:0]         sequence_ff;

   logic [COUNT_W-1:0]       n_eff;
   logic [PIN_W-1:0]         raw;
   logic [PIN_W-1:0]         act;
   logic [COUNT_W-1:0]       count;
   logic signed [COEF_W-1:0] coef [PIN_W];
   logic signed [COEF_W-1:0] coef_sum;
   logic signed [ODD_W-1:0]  odd_sum;

   assign req_full  = fifo_full;
   assign item_push = req_push && !fifo_full;

   // Channel i sits at (2i - (n-1)) half-pitches from the centre. The sum of the
   // odd coefficients' signs lets the back reproduce per-channel truncation.
   always_comb begin
      n_eff    = (channel_count_ff > COUNT_W'(MAX_CHANNELS)) ?
                 COUNT_W'(MAX_CHANNELS) : channel_count_ff;
      raw      = '0;
      act      = '0;
      count    = '0;
      coef_sum = '0;
      odd_sum  = '0;
      for (int i = 0; i < PIN_W; i++) begin
         coef[i] = COEF_W'(2 * i) - COEF_W'(n_eff) + COEF_W'(1);
         if (COUNT_W'(i) < n_eff) begin
            raw[i] = req_pin_levels[i];
            if (req_pin_levels[i] ^ active_low_ff) begin
               act[i]   = 1'b1;
               count    = count + COUNT_W'(1);
               coef_sum = coef_sum + coef[i];
               if (coef[i][0]) begin
                  odd_sum = coef[i][COEF_W-1] ? odd_sum - ODD_W'(1) : odd_sum + ODD_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      item.raw_bits     = raw;
      item.hit_bits     = act;
      item.hit_count    = count;
      item.toggled_bits = sampled_once_ff ? (act ^ prev_mask_ff) : '0;
      item.sequence_no  = sequence_ff;
      item.coef_sum     = coef_sum;
      item.odd_sum      = odd_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff    <= 1'b0;
         channel_count_ff <= COUNT_W'(8);
         prev_mask_ff     <= '0;
         sampled_once_ff  <= 1'b0;
         sequence_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ACTIVE_LOW:    active_low_ff    <= csr_wdata[0];
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (item_push) begin
            prev_mask_ff    <= act;
            sampled_once_ff <= 1'b1;
            sequence_ff     <= sequence_ff + SEQ_W'(1);
         end
      end
   end

endmodule

FILE: rtl/core/lsct_fifo.sv
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module lsct_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lsct_pkg::lsct_item_type wdata,
   output logic                    full,
   input  logic                    pop,
   output lsct_pkg::lsct_item_type rdata,
   output logic                    empty
);
   import lsct_pkg::*;

   localparam int DEPTH  = 2;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   lsct_item_type      entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic               do_push;
   logic               do_pop;

   assign full    = (fill_ff == FILL_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

endmodule

FILE: rtl/core/lsct_back.sv
// Back end: centroid scaling, serial division by the active count, line memory and result register.
`timescale 1ns / 1ps

module lsct_back #(
   parameter int PITCH_SCALE = 1000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  lsct_pkg::lsct_item_type             item,
   output logic                                item_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [lsct_pkg::PIN_W-1:0]          rsp_raw_mask,
   output logic [lsct_pkg::PIN_W-1:0]          rsp_active_mask,
   output logic [lsct_pkg::COUNT_W-1:0]        rsp_active_count,
   output logic                                rsp_line_detected,
   output logic signed [lsct_pkg::POS_W-1:0]   rsp_position,
   output logic signed [lsct_pkg::POS_W-1:0]   rsp_weighted_position,
   output logic signed [lsct_pkg::POS_W-1:0]   rsp_remembered_position,
   output logic [lsct_pkg::SIDE_W-1:0]         rsp_lost_side,
   output logic [lsct_pkg::LOST_W-1:0]         rsp_lost_count,
   output logic [lsct_pkg::PIN_W-1:0]          rsp_changed_mask,
   output logic [lsct_pkg::SEQ_W-1:0]          rsp_sequence_res
);
   import lsct_pkg::*;

   localparam int SCALE_W = $clog2(PITCH_SCALE + 1);
   localparam int PROD_W  = SCALE_W + COEF_W;
   localparam int QW      = PROD_W - 1;
   localparam int STEP_W  = $clog2(QW);
   localparam logic signed [PROD_W-1:0] SCALE_S = PROD_W'(PITCH_SCALE);
   localparam bit SCALE_ODD = (PITCH_SCALE % 2) == 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } state_type;

   state_type                state_ff;
   lsct_item_type            rec_ff;
   logic [QW-1:0]            dvd_ff;
   logic [2:0]               rem_ff;
   logic                     neg_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [POS_W-1:0]  mem_pos_ff;
   logic                     mem_valid_ff;
   logic [LOST_W-1:0]        lost_ff;
   logic                     out_valid_ff;

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] numer;
   logic signed [PROD_W-1:0] half;
   logic signed [PROD_W-1:0] half_abs;
   logic [COUNT_W-1:0]       trial;
   logic                     qbit;
   logic signed [QW:0]       quo_signed;
   logic signed [POS_W-1:0]  weighted;
   logic [LOST_W-1:0]        lost_next;
   logic [SIDE_W-1:0]        mem_side;
   logic                     out_free;
   logic                     out_load;

   assign item_pop  = (state_ff == ST_IDLE) && item_valid;
   assign out_free  = !out_valid_ff || rsp_pop;
   assign out_load  = (state_ff == ST_HOLD) && out_free;
   assign rsp_empty = !out_valid_ff;

   // Sum of the truncated channel offsets: (scale * sum_c - odd_adjust) / 2, always exact.
   always_comb begin
      prod     = PROD_W'(item.coef_sum) * SCALE_S;
      numer    = SCALE_ODD ? prod - PROD_W'(item.odd_sum) : prod;
      half     = numer >>> 1;
      half_abs = half[PROD_W-1] ? -half : half;
   end

   // One restoring division step per cycle; the remainder stays below the count.
   always_comb begin
      trial = {rem_ff, dvd_ff[QW-1]};
      qbit  = (trial >= rec_ff.hit_count);
   end

   always_comb begin
      quo_signed = $signed({1'b0, dvd_ff});
      if (neg_ff) begin
         quo_signed = -quo_signed;
      end
      weighted  = POS_W'(quo_signed);
      lost_next = (lost_ff == '1) ? lost_ff : lost_ff + LOST_W'(1);
      if (!mem_valid_ff || mem_pos_ff == '0) begin
         mem_side = SIDE_UNKNOWN;
      end else if (mem_pos_ff[POS_W-1]) begin
         mem_side = SIDE_LEFT;
      end else begin
         mem_side = SIDE_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mem_pos_ff   <= '0;
         mem_valid_ff <= 1'b0;
         lost_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  rec_ff  <= item;
                  dvd_ff  <= half_abs[QW-1:0];
                  neg_ff  <= half[PROD_W-1];
                  rem_ff  <= '0;
                  step_ff <= STEP_W'(QW - 1);
                  state_ff <= (item.hit_count == '0) ? ST_HOLD : ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= qbit ? 3'(trial - rec_ff.hit_count) : trial[2:0];
               dvd_ff <= {dvd_ff[QW-2:0], qbit};
               if (step_ff == '0) begin
                  state_ff <= ST_HOLD;
               end else begin
                  step_ff <= step_ff - STEP_W'(1);
               end
            end
            ST_HOLD: begin
               if (out_load) begin
                  out_valid_ff            <= 1'b1;
                  rsp_raw_mask            <= rec_ff.raw_bits;
                  rsp_active_mask         <= rec_ff.hit_bits;
                  rsp_active_count        <= rec_ff.hit_count;
                  rsp_changed_mask        <= rec_ff.toggled_bits;
                  rsp_sequence_res        <= rec_ff.sequence_no;
                  if (rec_ff.hit_count != '0) begin
                     rsp_line_detected       <= 1'b1;
                     rsp_position            <= weighted;
                     rsp_weighted_position   <= weighted;
                     rsp_remembered_position <= weighted;
                     rsp_lost_side           <= SIDE_UNKNOWN;
                     rsp_lost_count          <= '0;
                     mem_pos_ff              <= weighted;
                     mem_valid_ff            <= 1'b1;
                     lost_ff                 <= '0;
                  end else begin
                     rsp_line_detected       <= 1'b0;
                     rsp_position            <= mem_valid_ff ? mem_pos_ff : '0;
                     rsp_weighted_position   <= '0;
                     rsp_remembered_position <= mem_valid_ff ? mem_pos_ff : '0;
                     rsp_lost_side           <= mem_side;
                     rsp_lost_count          <= lost_next;
                     lost_ff                 <= lost_next;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: tb/tb_line_sensor_centroid_tracker_core.sv
// Self-checking testbench for the line sensor centroid tracker core.
`timescale 1ns / 1ps

module tb_line_sensor_centroid_tracker_core;

   import lsct_pkg::*;

   localparam int MAX_CH         = 8;
   localparam int PITCH_SCALE    = 1000;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 80;
   localparam int LONG_HOLD      = 400;
   localparam int TAIL_CYCLES    = 40;
   localparam int STALL_LIMIT    = 4000;
   localparam int LOST_RUN_ITEMS = 8;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [PIN_W-1:0]        raw_bits;
      logic [PIN_W-1:0]        hit_bits;
      logic [COUNT_W-1:0]      hit_count;
      logic                    on_line;
      logic signed [POS_W-1:0] position;
      logic signed [POS_W-1:0] centroid;
      logic signed [POS_W-1:0] recalled;
      logic [SIDE_W-1:0]       miss_side;
      logic [LOST_W-1:0]       miss_run;
      logic [PIN_W-1:0]        toggled_bits;
      logic [SEQ_W-1:0]        sequence_res;
   } track_report_type;

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     csr_we         = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index      = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata      = '0;
   logic                     req_push       = 1'b0;
   logic                     req_full;
   logic [PIN_W-1:0]         req_pin_levels = '0;
   logic                     rsp_empty;
   logic                     rsp_pop        = 1'b0;
   logic [PIN_W-1:0]         rsp_raw_mask;
   logic [PIN_W-1:0]         rsp_active_mask;
   logic [COUNT_W-1:0]       rsp_active_count;
   logic                     rsp_line_detected;
   logic signed [POS_W-1:0]  rsp_position;
   logic signed [POS_W-1:0]  rsp_weighted_position;
   logic signed [POS_W-1:0]  rsp_remembered_position;
   logic [SIDE_W-1:0]        rsp_lost_side;
   logic [LOST_W-1:0]        rsp_lost_count;
   logic [PIN_W-1:0]         rsp_changed_mask;
   logic [SEQ_W-1:0]         rsp_sequence_res;

   // Shadow of the configuration registers.
   logic                     cfg_active_low    = 1'b0;
   logic [CSR_DATA_W-1:0]    cfg_channel_count = 4'd8;

   // Tracker state as the predictor sees it.
   logic signed [POS_W-1:0]  memory_position   = '0;
   logic                     memory_valid      = 1'b0;
   logic [LOST_W-1:0]        lost_run          = '0;
   logic [PIN_W-1:0]         last_active_mask  = '0;
   logic                     seen_snapshot     = 1'b0;
   logic [SEQ_W-1:0]         snapshot_seq      = '0;

   logic [PIN_W-1:0]         pending_snapshots [$];
   track_report_type         awaited_reports [$];
   track_report_type         head_report;

   int issued_total   = 0;
   int accepted_total = 0;
   int checked_total  = 0;
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_orders    = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   int phase_channels [PHASES] = '{8, 1, 0, 15, 3, 9, 2, 5, 8, 4, 6, 7};
   logic [PIN_W-1:0] directed_pins [19] = '{
      8'h00, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h80, 8'h00, 8'h03, 8'h0D,
      8'hB0, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h18, 8'h81, 8'h7E, 8'h00
   };

   line_sensor_centroid_tracker_core #(
      .MAX_CHANNELS (MAX_CH),
      .PITCH_SCALE  (PITCH_SCALE)
   ) u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_pin_levels          (req_pin_levels),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_raw_mask            (rsp_raw_mask),
      .rsp_active_mask         (rsp_active_mask),
      .rsp_active_count        (rsp_active_count),
      .rsp_line_detected       (rsp_line_detected),
      .rsp_position            (rsp_position),
      .rsp_weighted_position   (rsp_weighted_position),
      .rsp_remembered_position (rsp_remembered_position),
      .rsp_lost_side           (rsp_lost_side),
      .rsp_lost_count          (rsp_lost_count),
      .rsp_changed_mask        (rsp_changed_mask),
      .rsp_sequence_res        (rsp_sequence_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Classifies one snapshot, works out its centroid and advances the tracker state.
   function automatic track_report_type track_snapshot(input logic [PIN_W-1:0] pins);
      track_report_type r;
      int n;
      int i;
      int sum;
      int weighted;
      r   = '0;
      sum = 0;
      n   = (cfg_channel_count > MAX_CH) ? MAX_CH : int'(cfg_channel_count);
      for (i = 0; i < n; i++) begin
         r.raw_bits[i] = pins[i];
         if (pins[i] ^ cfg_active_low) begin
            r.hit_bits[i] = 1'b1;
            r.hit_count   = r.hit_count + 1'b1;
            sum += ((2 * i - (n - 1)) * PITCH_SCALE) / 2;
         end
      end
      if (r.hit_count != 0) begin
         // Signed integer division truncates toward zero, as the centroid requires.
         weighted        = sum / int'(r.hit_count);
         r.on_line       = 1'b1;
         r.position      = 16'(weighted);
         r.centroid      = 16'(weighted);
         memory_position = 16'(weighted);
         memory_valid    = 1'b1;
         lost_run        = '0;
      end else begin
         if (lost_run != 16'hFFFF)
            lost_run = lost_run + 1'b1;
         r.miss_run = lost_run;
         if (memory_valid) begin
            r.position = memory_position;
            if (memory_position < 0)
               r.miss_side = SIDE_LEFT;
            else if (memory_position > 0)
               r.miss_side = SIDE_RIGHT;
            else
               r.miss_side = SIDE_UNKNOWN;
         end
      end
      r.recalled       = memory_valid ? memory_position : '0;
      r.toggled_bits   = seen_snapshot ? (r.hit_bits ^ last_active_mask) : '0;
      r.sequence_res   = snapshot_seq;
      snapshot_seq     = snapshot_seq + 1'b1;
      last_active_mask = r.hit_bits;
      seen_snapshot    = 1'b1;
      return r;
   endfunction

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                     field, checked_total, want, got);
      end
   endtask

   task automatic queue_snapshot(input logic [PIN_W-1:0] pins);
      pending_snapshots.push_back(pins);
      issued_total++;
   endtask

   // Mostly a line one to three channels wide, with runs of lost snapshots
   // and some noise; pins beyond the channels in use carry random levels.
   task automatic queue_track_run(input int items);
      int n;
      int kind;
      int run;
      int j;
      int k;
      logic [PIN_W-1:0] use_mask;
      logic [PIN_W-1:0] line;
      logic [PIN_W-1:0] levels;
      n        = (cfg_channel_count > MAX_CH) ? MAX_CH : int'(cfg_channel_count);
      use_mask = 8'((1 << n) - 1);
      k        = 0;
      while (k < items) begin
         kind = $urandom_range(9);
         run  = 1;
         line = '0;
         if (kind < 6 && n > 0)
            line = 8'(((1 << $urandom_range(3, 1)) - 1) << $urandom_range(n - 1)) & use_mask;
         else if (kind < 8)
            run = $urandom_range(6, 1);
         for (j = 0; j < run && k < items; j++) begin
            if (kind >= 8)
               levels = 8'($urandom);
            else
               levels = ((cfg_active_low ? ~line : line) & use_mask)
                        | (8'($urandom) & ~use_mask);
            queue_snapshot(levels);
            k++;
         end
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_ACTIVE_LOW)
         cfg_active_low = data[0];
      else
         cfg_channel_count = data;
   endtask

   task automatic wait_drained();
      while (accepted_total != issued_total || awaited_reports.size() != 0)
         @(posedge clock);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            awaited_reports.push_back(track_snapshot(req_pin_levels));
            accepted_total++;
         end
         if (!req_push || !req_full) begin
            if (pending_snapshots.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push       <= 1'b1;
               req_pin_levels <= pending_snapshots.pop_front();
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (awaited_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Unexpected result with sequence %0d", rsp_sequence_res);
            end else begin
               head_report = awaited_reports.pop_front();
               compare_field("raw mask", head_report.raw_bits, rsp_raw_mask);
               compare_field("active mask", head_report.hit_bits, rsp_active_mask);
               compare_field("active count", head_report.hit_count, rsp_active_count);
               compare_field("line flag", head_report.on_line, rsp_line_detected);
               compare_field("position", $signed(head_report.position), rsp_position);
               compare_field("centroid", $signed(head_report.centroid),
                             rsp_weighted_position);
               compare_field("memory", $signed(head_report.recalled),
                             rsp_remembered_position);
               compare_field("side", head_report.miss_side, rsp_lost_side);
               compare_field("lost run", head_report.miss_run, rsp_lost_count);
               compare_field("change mask", head_report.toggled_bits, rsp_changed_mask);
               compare_field("sequence", head_report.sequence_res, rsp_sequence_res);
            end
            checked_total++;
         end
         if (hold_orders != hold_served) begin
            hold_served = hold_orders;
            hold_left   = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles in which no request, result or register write goes through.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int p;
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed snapshots under the reset configuration: lost before any
      // detection, the centre, both ends, truncation on either side.
      for (k = 0; k < 19; k++)
         queue_snapshot(directed_pins[k]);
      wait_drained();

      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         write_csr(CSR_ACTIVE_LOW, 4'(p % 2));
         write_csr(CSR_CHANNEL_COUNT, 4'(phase_channels[p]));
         // Hold the result side off while requests keep coming, so the block fills.
         if (p == 0)
            hold_orders++;
         queue_track_run(PHASE_ITEMS);
         wait_drained();
         queue_track_run(PHASE_ITEMS);
         wait_drained();
      end

      // A run of lost snapshots framed by detections on either side.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_csr(CSR_ACTIVE_LOW, 4'd1);
      write_csr(CSR_CHANNEL_COUNT, 4'd2);
      queue_snapshot(8'h01 | (8'($urandom) & 8'hFC));
      for (k = 0; k < LOST_RUN_ITEMS; k++)
         queue_snapshot(8'h03 | (8'($urandom) & 8'hFC));
      queue_snapshot(8'h02);
      queue_snapshot(8'h03);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
